>>> src/connection_timeout_queue_unit_macros.svh
// Assertion macros for the checker file of the timeout queue.
`ifndef CONNECTION_TIMEOUT_QUEUE_UNIT_MACROS_SVH
`define CONNECTION_TIMEOUT_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CTQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ctq_pkg.sv
// Types, constants and codes of the connection timeout queue.
`timescale 1ns / 1ps
package ctq_pkg;

   localparam int CAPACITY    = 64;
   localparam int CONN_BITS   = 10;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int CONN_ID_W   = 10;
   localparam int SEQ_W       = 16;
   localparam int TIME_W      = 32;
   localparam int WAIT_W      = 16;
   localparam int STAMP_W     = 32;
   localparam int REMOVED_W   = 7;
   localparam int KEY_W       = (CONN_BITS < CONN_ID_W) ? CONN_BITS : CONN_ID_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(20);

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_TICK   = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_CLEAR  = 2'd3
   } ctq_action_type;

   typedef enum logic [2:0] {
      ST_EXPIRED  = 3'd0,
      ST_ADD_OK   = 3'd1,
      ST_ADD_FULL = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_NONE_DUE = 3'd4
   } ctq_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAIT_TIME = 1'd0,
      CSR_KICK      = 1'd1
   } ctq_csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_SCAN,
      S_DEL_SCAN,
      S_DUE_SCAN,
      S_MIN_SCAN,
      S_POP
   } ctq_state_type;

   typedef struct packed {
      ctq_action_type         action;
      logic [CONN_ID_W-1:0]   conn_id;
      logic [SEQ_W-1:0]       conn_sequence;
      logic [TIME_W-1:0]      now;
   } ctq_req_type;

   typedef struct packed {
      ctq_status_type         status;
      logic [CONN_ID_W-1:0]   out_conn;
      logic [SEQ_W-1:0]       out_sequence;
      logic [REMOVED_W-1:0]   removed_count;
      logic                   last;
   } ctq_rsp_type;

   // One table entry as held in the entry memory.
   typedef struct packed {
      logic [TIME_W-1:0]      deadline;
      logic [KEY_W-1:0]       conn;
      logic [SEQ_W-1:0]       seq;
      logic [STAMP_W-1:0]     order;
   } ctq_entry_type;

   localparam int ENTRY_W = $bits(ctq_entry_type);

   // Flags from the shared compare unit for the entry just read.
   typedef struct packed {
      logic                   due;
      logic                   conn_match;
      logic                   better;
      logic [STAMP_W-1:0]     age;
   } ctq_cmp_type;

endpackage

>>> src/ctq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ctq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/ctq_cmp.sv
// Shared compare unit: due test, connection match and earliest-entry ordering.
`timescale 1ns / 1ps
module ctq_cmp (
   input  ctq_pkg::ctq_entry_type       entry,
   input  logic [ctq_pkg::KEY_W-1:0]    key,
   input  logic [ctq_pkg::TIME_W-1:0]   now,
   input  logic [ctq_pkg::STAMP_W-1:0]  stamp,
   input  logic [ctq_pkg::TIME_W-1:0]   best_deadline,
   input  logic [ctq_pkg::STAMP_W-1:0]  best_age,
   output ctq_pkg::ctq_cmp_type         res
);
   import ctq_pkg::*;

   logic [STAMP_W-1:0] age;

   // Age is measured back from the current stamp, so it survives wrapping.
   assign age = stamp - entry.order;

   always_comb begin
      res.due        = (entry.deadline <= now);
      res.conn_match = (entry.conn == key);
      res.better     = (entry.deadline < best_deadline) ||
                       ((entry.deadline == best_deadline) && (age > best_age));
      res.age        = age;
   end

endmodule

>>> src/connection_timeout_queue_unit.sv
// Top level of the connection timeout queue: sequencer, entry table and compare unit.
//
//   channel   ports                                  handshake
//   request   start, busy, req_data                  taken when start and not busy
//   result    rsp_strobe, rsp_data                   one-cycle strobe per word, no back-pressure
//   config    csr_we, csr_index, csr_wdata           written when csr_we is high
//
// Clear answers straight from idle; add searches for a free slot, one slot a cycle in the
// free-slot search. Delete makes one pass over the table through the entry memory read port.
// A tick makes a due pass and then, for each expired word, a full minimum search and a pop,
// as every pop repeats the minimum search through the same read port and compare unit.
// Reset clears the valid bits directly; there is no clearing pass.
// Results cannot be stalled; the last word of an item appears as busy falls.
`timescale 1ns / 1ps
module connection_timeout_queue_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ctq_pkg::ctq_req_type              req_data,
   input  logic                              csr_we,
   input  logic [ctq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ctq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_strobe,
   output ctq_pkg::ctq_rsp_type              rsp_data
);
   import ctq_pkg::*;

   ctq_state_type        state_ff, state_in;
   logic [CAPACITY-1:0]  valid_ff, valid_in;
   logic [CAPACITY-1:0]  due_ff, due_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   pending_ff, pending_in;
   logic [COUNT_W-1:0]   removed_ff, removed_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic                 kick_ff, kick_in;

   logic [KEY_W-1:0]     key_ff, key_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    dl_new_ff, dl_new_in;

   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 issue_ff, issue_in;
   logic                 pv_ff, pv_in;
   logic [IDX_W-1:0]     pv_idx_ff, pv_idx_in;

   logic                 best_found_ff, best_found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]    best_dl_ff, best_dl_in;
   logic [STAMP_W-1:0]   best_age_ff, best_age_in;
   logic [KEY_W-1:0]     best_conn_ff, best_conn_in;
   logic [SEQ_W-1:0]     best_seq_ff, best_seq_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   ctq_rsp_type          rsp_ff, rsp_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   ctq_entry_type        ram_wdata;
   ctq_entry_type        ram_rdata;
   ctq_cmp_type          cmp_res;

   logic [TIME_W:0]      dl_sum;
   logic                 scan_end;
   logic                 del_hit;
   logic                 due_hit;
   logic                 min_take;
   logic [COUNT_W-1:0]   removed_next;
   logic [COUNT_W-1:0]   pending_next;

   ctq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (scan_idx_ff),
      .rdata (ram_rdata)
   );

   ctq_cmp u_cmp (
      .entry         (ram_rdata),
      .key           (key_ff),
      .now           (now_ff),
      .stamp         (stamp_ff),
      .best_deadline (best_dl_ff),
      .best_age      (best_age_ff),
      .res           (cmp_res)
   );

   // Deadline of a new or re-armed entry, saturating at the top of the time range.
   assign dl_sum = {1'b0, req_data.now} + (TIME_W + 1)'(wait_ff);

   // The read pipeline delivers the last entry of a pass.
   assign scan_end     = pv_ff && (pv_idx_ff == IDX_W'(CAPACITY - 1));
   assign del_hit      = pv_ff && valid_ff[pv_idx_ff] && cmp_res.conn_match;
   assign due_hit      = pv_ff && valid_ff[pv_idx_ff] && cmp_res.due;
   assign min_take     = pv_ff && due_ff[pv_idx_ff] && (!best_found_ff || cmp_res.better);
   assign removed_next = removed_ff + COUNT_W'(del_hit);
   assign pending_next = pending_ff + COUNT_W'(due_hit);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_data.action)
                  ACT_ADD: begin
                     if (count_ff != COUNT_W'(CAPACITY)) begin
                        state_in = S_ADD_SCAN;
                     end
                  end
                  ACT_TICK:   state_in = S_DUE_SCAN;
                  ACT_DELETE: state_in = S_DEL_SCAN;
                  ACT_CLEAR:  state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_SCAN: begin
            if (!valid_ff[scan_idx_ff]) begin
               state_in = S_IDLE;
            end
         end
         S_DEL_SCAN: begin
            if (scan_end) begin
               state_in = S_IDLE;
            end
         end
         S_DUE_SCAN: begin
            if (scan_end) begin
               state_in = (pending_next == '0) ? S_IDLE : S_MIN_SCAN;
            end
         end
         S_MIN_SCAN: begin
            if (scan_end) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            state_in = (pending_ff == COUNT_W'(1)) ? S_IDLE : S_MIN_SCAN;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in      = valid_ff;
      due_in        = due_ff;
      count_in      = count_ff;
      pending_in    = pending_ff;
      removed_in    = removed_ff;
      stamp_in      = stamp_ff;
      wait_in       = wait_ff;
      kick_in       = kick_ff;
      key_in        = key_ff;
      seq_in        = seq_ff;
      now_in        = now_ff;
      dl_new_in     = dl_new_ff;
      scan_idx_in   = scan_idx_ff;
      issue_in      = issue_ff;
      pv_in         = 1'b0;
      pv_idx_in     = pv_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_age_in   = best_age_ff;
      best_conn_in  = best_conn_ff;
      best_seq_in   = best_seq_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = best_idx_ff;
      ram_wdata     = '{deadline: dl_new_ff, conn: best_conn_ff, seq: best_seq_ff,
                        order: stamp_ff};

      if (csr_we) begin
         unique case (ctq_csr_type'(csr_index))
            CSR_WAIT_TIME: wait_in = csr_wdata[WAIT_W-1:0];
            CSR_KICK:      kick_in = csr_wdata[0];
         endcase
      end

      // Read issue for the three scanning passes, one address a cycle.
      if ((state_ff == S_DEL_SCAN || state_ff == S_DUE_SCAN || state_ff == S_MIN_SCAN)
          && issue_ff) begin
         pv_in       = 1'b1;
         pv_idx_in   = scan_idx_ff;
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         if (scan_idx_ff == IDX_W'(CAPACITY - 1)) begin
            issue_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in      = req_data.conn_id[KEY_W-1:0];
               seq_in      = req_data.conn_sequence;
               now_in      = req_data.now;
               dl_new_in   = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
               scan_idx_in = '0;
               unique case (req_data.action)
                  ACT_ADD: begin
                     if (count_ff == COUNT_W'(CAPACITY)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = '0;
                        rsp_in.status = ST_ADD_FULL;
                        rsp_in.last   = 1'b1;
                     end
                  end
                  ACT_TICK: begin
                     issue_in   = 1'b1;
                     pending_in = '0;
                     due_in     = '0;
                  end
                  ACT_DELETE: begin
                     issue_in   = 1'b1;
                     removed_in = '0;
                  end
                  ACT_CLEAR: begin
                     valid_in             = '0;
                     count_in             = '0;
                     rsp_strobe_in        = 1'b1;
                     rsp_in               = '0;
                     rsp_in.status        = ST_REMOVED;
                     rsp_in.removed_count = REMOVED_W'(count_ff);
                     rsp_in.last          = 1'b1;
                  end
               endcase
            end
         end
         S_ADD_SCAN: begin
            if (valid_ff[scan_idx_ff]) begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end else begin
               ram_we                = 1'b1;
               ram_waddr             = scan_idx_ff;
               ram_wdata             = '{deadline: dl_new_ff, conn: key_ff, seq: seq_ff,
                                         order: stamp_ff};
               valid_in[scan_idx_ff] = 1'b1;
               count_in              = count_ff + COUNT_W'(1);
               stamp_in              = stamp_ff + STAMP_W'(1);
               rsp_strobe_in         = 1'b1;
               rsp_in                = '0;
               rsp_in.status         = ST_ADD_OK;
               rsp_in.last           = 1'b1;
            end
         end
         S_DEL_SCAN: begin
            if (del_hit) begin
               valid_in[pv_idx_ff] = 1'b0;
            end
            removed_in = removed_next;
            if (scan_end) begin
               count_in             = count_ff - removed_next;
               rsp_strobe_in        = 1'b1;
               rsp_in               = '0;
               rsp_in.status        = ST_REMOVED;
               rsp_in.removed_count = REMOVED_W'(removed_next);
               rsp_in.last          = 1'b1;
            end
         end
         S_DUE_SCAN: begin
            if (due_hit) begin
               due_in[pv_idx_ff] = 1'b1;
            end
            pending_in = pending_next;
            if (scan_end) begin
               if (pending_next == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  rsp_in.status = ST_NONE_DUE;
                  rsp_in.last   = 1'b1;
               end else begin
                  scan_idx_in   = '0;
                  issue_in      = 1'b1;
                  best_found_in = 1'b0;
               end
            end
         end
         S_MIN_SCAN: begin
            if (min_take) begin
               best_found_in = 1'b1;
               best_idx_in   = pv_idx_ff;
               best_dl_in    = ram_rdata.deadline;
               best_age_in   = cmp_res.age;
               best_conn_in  = ram_rdata.conn;
               best_seq_in   = ram_rdata.seq;
            end
         end
         S_POP: begin
            rsp_strobe_in       = 1'b1;
            rsp_in              = '0;
            rsp_in.status       = ST_EXPIRED;
            rsp_in.out_conn     = CONN_ID_W'(best_conn_ff);
            rsp_in.out_sequence = best_seq_ff;
            rsp_in.last         = (pending_ff == COUNT_W'(1));
            due_in[best_idx_ff] = 1'b0;
            pending_in          = pending_ff - COUNT_W'(1);
            if (kick_ff) begin
               valid_in[best_idx_ff] = 1'b0;
               count_in              = count_ff - COUNT_W'(1);
            end else begin
               // Re-armed entry keeps its connection and sequence, gets a fresh stamp.
               ram_we   = 1'b1;
               stamp_in = stamp_ff + STAMP_W'(1);
            end
            if (pending_ff != COUNT_W'(1)) begin
               scan_idx_in   = '0;
               issue_in      = 1'b1;
               best_found_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         due_ff        <= '0;
         count_ff      <= '0;
         pending_ff    <= '0;
         stamp_ff      <= '0;
         wait_ff       <= WAIT_RESET;
         kick_ff       <= 1'b0;
         issue_ff      <= 1'b0;
         pv_ff         <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         due_ff        <= due_in;
         count_ff      <= count_in;
         pending_ff    <= pending_in;
         stamp_ff      <= stamp_in;
         wait_ff       <= wait_in;
         kick_ff       <= kick_in;
         issue_ff      <= issue_in;
         pv_ff         <= pv_in;
         best_found_ff <= best_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff   <= removed_in;
      key_ff       <= key_in;
      seq_ff       <= seq_in;
      now_ff       <= now_in;
      dl_new_ff    <= dl_new_in;
      scan_idx_ff  <= scan_idx_in;
      pv_idx_ff    <= pv_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dl_ff   <= best_dl_in;
      best_age_ff  <= best_age_in;
      best_conn_ff <= best_conn_in;
      best_seq_ff  <= best_seq_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> src/connection_timeout_queue_unit_checker.sv
// Port-level checker for the connection timeout queue and its bind.
`timescale 1ns / 1ps
`include "connection_timeout_queue_unit_macros.svh"
module connection_timeout_queue_unit_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input ctq_pkg::ctq_rsp_type rsp_data
);
   import ctq_pkg::*;

   // An accepted request either starts work or answers at once.
   `CTQ_ASSERT_NEXT(a_accept_acts, clock, reset, start && !busy, busy || rsp_strobe, "accepted request left no trace")

   // Only expired-entry words may be followed by more words of the same item.
   `CTQ_ASSERT_IMP(a_single_word, clock, reset, rsp_strobe && rsp_data.status != ST_EXPIRED, rsp_data.last, "single-word result not marked last")

   // The final word of an item coincides with the block going idle.
   `CTQ_ASSERT_IMP(a_last_idle, clock, reset, rsp_strobe && rsp_data.last, !busy, "busy after final word")

   // A word that is not final means the item is still in progress.
   `CTQ_ASSERT_IMP(a_more_busy, clock, reset, rsp_strobe && !rsp_data.last, busy, "idle with words outstanding")

endmodule

bind connection_timeout_queue_unit connection_timeout_queue_unit_checker u_checker (.*);
